// ===== rtl/core/eve_pkg.sv =====
// Package: shared types and constants for the encoder velocity estimator.
package eve_pkg;
   localparam int GROUP_COUNTS = 4;
   localparam logic [30:0] PI_Q29 = 31'd1686629713;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   localparam logic [1:0] REG_INVERT = 2'd0;
   localparam logic [1:0] REG_CPR = 2'd1;
   localparam logic [1:0] REG_DIAM = 2'd2;
   localparam logic [1:0] REG_TIMEOUT = 2'd3;

   typedef struct packed {
      logic        invert;
      logic [15:0] cpr;
      logic [19:0] diam;
      logic [23:0] timeout;
   } cfg_type;

   // classified job handed from front to back
   typedef struct packed {
      logic [31:0] position;
      logic        compute;
      logic        neg;
      logic [17:0] mag;
      logic [47:0] window;
      logic        status;
   } job_type;
endpackage

// ===== rtl/core/eve_front.sv =====
// Front: accepts items, keeps position, counts and timing, classifies work.
module eve_front (
   input  logic                 clock,
   input  logic                 reset,
   input  eve_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_func,
   input  logic [47:0]          in_now,
   input  logic signed [15:0]   in_delta,
   output logic                 job_valid,
   input  logic                 job_ready,
   output eve_pkg::job_type     job,
   output logic                 job_clear
);
   logic [31:0] position_ff, position_in;
   logic signed [2:0] carried_ff, carried_in;
   logic [47:0] last_ff, last_in, wstart_ff, wstart_in;
   logic valid_ff;
   eve_pkg::job_type job_ff, job_in;
   logic clear_ff, clear_in;

   logic signed [17:0] delta_s, total, rem, usable, used;
   logic [47:0] window;
   logic window_expired;

   assign in_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job = job_ff;
   assign job_clear = clear_ff;

   always_comb begin
      delta_s = cfg.invert ? -18'(in_delta) : 18'(in_delta);
      total = 18'(carried_ff) + delta_s;
      rem = total % 18'(eve_pkg::GROUP_COUNTS);
      usable = total - rem;
      window = in_now - wstart_ff;
      window_expired = window >= 48'(cfg.timeout);
      used = (usable != 18'sd0) ? usable : total;
      position_in = position_ff;
      carried_in = carried_ff;
      last_in = last_ff;
      wstart_in = wstart_ff;
      clear_in = 1'b0;
      job_in = '0;
      if (in_func) begin
         position_in = '0;
         carried_in = '0;
         last_in = in_now;
         wstart_in = in_now;
         clear_in = 1'b1;
      end else if (in_now <= last_ff) begin
         job_in.status = 1'b1;
      end else begin
         position_in = position_ff + 32'(delta_s);
         last_in = in_now;
         if (usable == 18'sd0 && !window_expired) begin
            carried_in = 3'(total);
         end else begin
            carried_in = 3'(total - used);
            wstart_in = in_now;
            job_in.compute = 1'b1;
            job_in.neg = used[17];
            job_in.mag = used[17] ? -used : used;
            job_in.window = (window == '0) ? 48'd1 : window;
         end
      end
      job_in.position = position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         position_ff <= '0;
         carried_ff <= '0;
         last_ff <= '0;
         wstart_ff <= '0;
      end else begin
         if (in_valid && in_ready) begin
            valid_ff <= 1'b1;
            position_ff <= position_in;
            carried_ff <= carried_in;
            last_ff <= last_in;
            wstart_ff <= wstart_in;
         end else if (job_ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (in_valid && in_ready) begin
         job_ff <= job_in;
         clear_ff <= clear_in;
      end
   end
endmodule

// ===== rtl/core/eve_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module eve_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [47:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff, q_in;
   logic [48:0] r_ff, r_in;
   logic [47:0] d_ff;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff;
   logic [48:0] trial;

   assign quotient = q_ff;
   assign done = busy_ff && cnt_ff == 7'd0;

   always_comb begin
      trial = {r_ff[47:0], q_ff[63]};
      q_in = {q_ff[62:0], 1'b0};
      r_in = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
      cnt_in = cnt_ff - 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= 7'd64;
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff && cnt_ff != 7'd0) begin
         cnt_ff <= cnt_in;
         q_ff <= q_in;
         r_ff <= r_in;
      end else begin
         busy_ff <= 1'b0;
      end
   end
endmodule

// ===== rtl/core/eve_back.sv =====
// Back: computes speeds with a shared divider and drives the result register.
module eve_back (
   input  logic              clock,
   input  logic              reset,
   input  eve_pkg::cfg_type  cfg,
   input  logic              job_valid,
   output logic              job_ready,
   input  eve_pkg::job_type  job,
   input  logic              job_clear,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [31:0]       out_position,
   output logic [31:0]       out_rps,
   output logic [31:0]       out_mps,
   output logic              out_fresh,
   output logic              out_status
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_MUL = 8'b00000010, S_D1 = 8'b00000100,
      S_D2 = 8'b00001000, S_D3 = 8'b00010000, S_D4 = 8'b00100000,
      S_PI = 8'b01000000, S_OUT = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] rps_ff, mps_ff;
   logic [63:0] a_ff, b_ff;
   logic [63:0] prod_ff;
   logic neg_ff;
   logic [47:0] win_ff;
   logic ov_ff;
   logic div_start;
   logic [63:0] div_num;
   logic [47:0] div_den;
   logic div_done;
   logic [63:0] div_q;
   logic ovalid_ff;
   logic ovalid_set;
   logic [31:0] opos_ff, orps_ff, omps_ff;
   logic ofresh_ff, ostat_ff;
   logic [15:0] cpr;

   assign cpr = (cfg.cpr == '0) ? 16'd1 : cfg.cpr;
   assign out_valid = ovalid_ff;
   assign out_position = opos_ff;
   assign out_rps = orps_ff;
   assign out_mps = omps_ff;
   assign out_fresh = ofresh_ff;
   assign out_status = ostat_ff;
   assign job_ready = (state_ff == S_IDLE && (!ovalid_ff || out_ready)
                       && !(job_valid && job.compute)) || state_ff == S_OUT;
   assign ovalid_set = (state_ff == S_IDLE && job_valid && job_ready) || state_ff == S_OUT;

   function automatic logic [31:0] sat(input logic [63:0] m, input logic n);
      if (n) return (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
      return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
   endfunction

   eve_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      div_start = 1'b0;
      div_num = a_ff;
      div_den = win_ff;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (job_valid && job.compute && (!ovalid_ff || out_ready))
            state_in = S_MUL;
         S_MUL: begin div_start = 1'b1; state_in = S_D1; end
         S_D1: if (div_done) begin
            div_start = 1'b1; div_num = div_q; div_den = 48'(cpr); state_in = S_D2;
         end
         S_D2: if (div_done) begin
            div_start = 1'b1; div_num = b_ff; state_in = S_D3;
         end
         S_D3: if (div_done) begin
            div_start = 1'b1; div_num = div_q; div_den = 48'(cpr); state_in = S_D4;
         end
         S_D4: if (div_done) state_in = S_PI;
         S_PI: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ovalid_ff <= 1'b0;
         rps_ff <= '0;
         mps_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (ovalid_set) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid && job_ready) begin
                  opos_ff <= job.position;
                  orps_ff <= job_clear ? '0 : rps_ff;
                  omps_ff <= job_clear ? '0 : mps_ff;
                  ofresh_ff <= 1'b0;
                  ostat_ff <= job.status;
                  if (job_clear) begin rps_ff <= '0; mps_ff <= '0; end
               end
               if (job_valid && job.compute) begin
                  neg_ff <= job.neg;
                  win_ff <= job.window;
                  a_ff <= (64'(job.mag) * 64'(eve_pkg::USEC_PER_SEC)) << 16;
                  b_ff <= (64'(job.mag) * 64'(cfg.diam)) << 18;
               end
            end
            S_D2: if (div_done) rps_ff <= sat(div_q, neg_ff);
            S_D4: if (div_done) begin
               ov_ff <= div_q >= 64'h2_0000_0000;
               prod_ff <= 64'(div_q[32:0]) * 64'(eve_pkg::PI_Q29);
            end
            S_PI: mps_ff <= sat(ov_ff ? 64'h1_0000_0000 : 64'(prod_ff[63:31]), neg_ff);
            S_OUT: begin
               opos_ff <= job.position;
               orps_ff <= rps_ff;
               omps_ff <= mps_ff;
               ofresh_ff <= 1'b1;
               ostat_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== rtl/core/eve_csr.sv =====
// Configuration registers behind an APB-style port.
module eve_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output eve_pkg::cfg_type  cfg
);
   eve_pkg::cfg_type cfg_ff;
   logic [1:0] idx;
   assign idx = paddr[3:2];
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      unique case (idx)
         eve_pkg::REG_INVERT: prdata = 32'(cfg_ff.invert);
         eve_pkg::REG_CPR: prdata = 32'(cfg_ff.cpr);
         eve_pkg::REG_DIAM: prdata = 32'(cfg_ff.diam);
         default: prdata = 32'(cfg_ff.timeout);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.invert <= 1'b0;
         cfg_ff.cpr <= 16'd1024;
         cfg_ff.diam <= 20'd65000;
         cfg_ff.timeout <= 24'd100000;
      end else if (psel && penable && pwrite) begin
         unique case (idx)
            eve_pkg::REG_INVERT: cfg_ff.invert <= pwdata[0];
            eve_pkg::REG_CPR: cfg_ff.cpr <= pwdata[15:0];
            eve_pkg::REG_DIAM: cfg_ff.diam <= pwdata[19:0];
            default: cfg_ff.timeout <= pwdata[23:0];
         endcase
      end
   end
endmodule

// ===== rtl/core/encoder_velocity_estimator_top.sv =====
// Encoder velocity estimator top level.
// Path: front job register, then back output register; a recompute also runs states MUL, D1-D4, PI.
// Throughput: one item per cycle if held and rsp_ready is high; recompute: four 64-step divisions.
// Reset: synchronous, clears position, counts, times, speeds and config to defaults.
module encoder_velocity_estimator_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [47:0]        req_now_us,
   input  logic signed [15:0] req_raw_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_position_count,
   output logic signed [31:0] rsp_speed_rps,
   output logic signed [31:0] rsp_speed_mps,
   output logic               rsp_speed_fresh,
   output logic               rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   eve_pkg::cfg_type cfg;
   eve_pkg::job_type job;
   logic job_valid, job_ready, job_clear;

   eve_csr u_csr (.clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready, .cfg);

   eve_front u_front (.clock, .reset, .cfg,
      .in_valid(req_valid), .in_ready(req_ready), .in_func(req_func),
      .in_now(req_now_us), .in_delta(req_raw_delta), .job_valid, .job_ready,
      .job, .job_clear);

   eve_back u_back (.clock, .reset, .cfg, .job_valid, .job_ready, .job, .job_clear,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_position(rsp_position_count),
      .out_rps(rsp_speed_rps), .out_mps(rsp_speed_mps), .out_fresh(rsp_speed_fresh),
      .out_status(rsp_status));
endmodule
